// ===== src/pera_pkg.sv =====
// Shared constants and types for the per-element running average core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pera_pkg;

	localparam int IDX_W     = 12;
	localparam int DATA_W    = 32;
	localparam int WIN_W     = 16;
	localparam int ELEMENTS  = 4096;
	localparam int ADDR_W    = $clog2(ELEMENTS);
	localparam int DIV_STEPS = DATA_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	// (d-1)*avg + sample never exceeds d * 2^31 in magnitude, so 48 bits hold it
	localparam int MAG_W     = DATA_W + WIN_W;
	localparam int PROD_W    = DATA_W + WIN_W + 1;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [WIN_W-1:0]         win_t;
	typedef logic [ADDR_W-1:0]        addr_t;

endpackage

// ===== src/pera_in_if.sv =====
// Input channel of the running average core: valid/ready plus one sample word.
// Depends on pera_pkg.
`timescale 1ns / 1ps

interface pera_in_if import pera_pkg::*; ();
	logic  valid;
	logic  ready;
	idx_t  element_index;
	data_t sample;
	logic  last_in_frame;

	modport source (output valid, element_index, sample, last_in_frame, input ready);
	modport sink   (input valid, element_index, sample, last_in_frame, output ready);
endinterface

// ===== src/pera_out_if.sv =====
// Output channel of the running average core: valid/ready plus one result word.
// Depends on pera_pkg.
`timescale 1ns / 1ps

interface pera_out_if import pera_pkg::*; ();
	logic  valid;
	logic  ready;
	idx_t  element_index_out;
	data_t average;

	modport source (output valid, element_index_out, average, input ready);
	modport sink   (input valid, element_index_out, average, output ready);
endinterface

// ===== src/per_element_running_average_core.sv =====
// Top level of the per-element running average core: sequencer, average store
// and shared bit-serial divider. Depends on pera_pkg, pera_in_if, pera_out_if.
`timescale 1ns / 1ps

// Keeps one signed Q16.16 running average per element. Each word on the
// samples channel (element_index, sample, last_in_frame) updates its element
// to ((d-1)*avg + sample)/d with d = min(frame count, window_count), rounded
// toward zero, and yields one word on the results channel carrying the index
// and the new average. last_in_frame advances the frame count up to the window.
// cfg_we/cfg_wdata write window_count (zero acts as one); write it only while
// the core is idle.
// From the accepting edge to results.valid the core steps through store read,
// multiply, add/absolute value, restoring division (one quotient bit per
// cycle) and write-back. A new word is accepted only once the core is back in
// idle, so it takes no new word before the last one is through.
// samples.ready is high only while the core is idle.
// Reset: frame count goes to one, window_count to 10, and a clearing pass
// zeroes the 4096-entry store, one entry per cycle; no word is accepted
// until it ends.
// Stall: the result is held in an output register; while that register holds
// an untaken result, the core holds the finished word and does not write back.

module per_element_running_average_core import pera_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  win_t          cfg_wdata,
	pera_in_if.sink       samples,
	pera_out_if.source    results
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                   state_q;
	addr_t                    clr_addr_q;
	win_t                     window_q;
	win_t                     frame_q;
	idx_t                     idx_q;
	data_t                    sample_q;
	logic                     last_q;
	logic                     in_range_q;
	win_t                     d_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;
	logic [WIN_W-1:0]         rem_q;
	logic [DATA_W-1:0]        quot_q;
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	idx_t                     out_idx_q;
	data_t                    out_avg_q;
	data_t                    rd_data_q;

	data_t                    mem [ELEMENTS];

	win_t                     eff_window;
	win_t                     d_next;
	data_t                    old_avg;
	logic signed [PROD_W-1:0] num;
	logic [PROD_W-1:0]        mag;
	logic [WIN_W:0]           trial;
	logic [WIN_W:0]           shifted;
	data_t                    avg;
	logic                     out_free;
	logic                     mem_we;
	addr_t                    mem_waddr;
	data_t                    mem_wdata;

	assign eff_window = (window_q == '0) ? WIN_W'(1) : window_q;
	assign d_next     = (frame_q < eff_window) ? frame_q : eff_window;
	assign old_avg    = in_range_q ? rd_data_q : '0;
	assign num        = prod_q + PROD_W'(sample_q);
	assign mag        = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);

	// one restoring step: bring down the next dividend bit and try to subtract d
	assign shifted = {rem_q, quot_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, d_q};

	assign avg      = neg_q ? data_t'(-quot_q) : data_t'(quot_q);
	assign out_free = !out_valid_q || results.ready;

	assign samples.ready = (state_q == ST_IDLE);

	assign results.valid             = out_valid_q;
	assign results.element_index_out = out_idx_q;
	assign results.average           = out_avg_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(idx_q);
		mem_wdata = avg;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (state_q == ST_DONE && out_free && in_range_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[ADDR_W'(idx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			window_q    <= WINDOW_RESET;
			frame_q     <= WIN_W'(1);
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			// in ST_DONE the output register is reloaded instead
			if (results.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(ELEMENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (samples.valid) begin
						idx_q      <= samples.element_index;
						sample_q   <= samples.sample;
						last_q     <= samples.last_in_frame;
						in_range_q <= 32'(samples.element_index) < 32'(ELEMENTS);
						d_q        <= d_next;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= $signed({1'b0, d_q - WIN_W'(1)}) * old_avg;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					// the quotient fits 32 bits, so the top 16 bits start as remainder
					neg_q   <= num[PROD_W-1];
					rem_q   <= mag[MAG_W-1:DATA_W];
					quot_q  <= mag[DATA_W-1:0];
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!trial[WIN_W]) begin
						rem_q  <= trial[WIN_W-1:0];
						quot_q <= {quot_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q  <= shifted[WIN_W-1:0];
						quot_q <= {quot_q[DATA_W-2:0], 1'b0};
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= idx_q;
						out_avg_q   <= avg;
						if (last_q && frame_q < eff_window) begin
							frame_q <= frame_q + WIN_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
